[rtl/core/jhb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package jhb_pkg;

  localparam int MAX_BINS    = 64;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int ADDR_W      = 2 * BIN_W;
  localparam int STORE_DEPTH = MAX_BINS * MAX_BINS;
  localparam int COUNT_W     = 32;
  localparam int SAMPLE_W    = 32;
  localparam int BINS_REG_W  = 7;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int INDEX_W     = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_MIN   = 3'd0,
    REG_X_MAX   = 3'd1,
    REG_X_SCALE = 3'd2,
    REG_Y_MIN   = 3'd3,
    REG_Y_MAX   = 3'd4,
    REG_Y_SCALE = 3'd5,
    REG_BINS_X  = 3'd6,
    REG_BINS_Y  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_BIN,
    ST_INDEX,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic clear;
    logic mem_rd;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

  // 0 acts as 1, anything above the store's axis size acts as the axis size
  function automatic logic [BINS_REG_W-1:0] clamp_bins(input logic [BINS_REG_W-1:0] b);
    logic [BINS_REG_W-1:0] r;
    r = b;
    if (b == '0) begin
      r = BINS_REG_W'(1);
    end else if (b > BINS_REG_W'(MAX_BINS)) begin
      r = BINS_REG_W'(MAX_BINS);
    end
    return r;
  endfunction

  function automatic logic [BIN_W-1:0] quantize(
    input logic                  at_max,
    input logic                  below_min,
    input logic [SAMPLE_W-1:0]   bin_raw,
    input logic [BINS_REG_W-1:0] nbins
  );
    logic [BINS_REG_W-1:0] top;
    logic [BIN_W-1:0]      r;
    top = nbins - BINS_REG_W'(1);
    if (at_max) begin
      r = top[BIN_W-1:0];
    end else if (below_min) begin
      r = '0;
    end else if (bin_raw >= SAMPLE_W'(nbins)) begin
      r = top[BIN_W-1:0];
    end else begin
      r = bin_raw[BIN_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/jhb_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface jhb_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [jhb_pkg::SAMPLE_W-1:0] x_sample;
  logic signed [jhb_pkg::SAMPLE_W-1:0] y_sample;

  modport source (output valid, output x_sample, output y_sample, input ready);
  modport sink (input valid, input x_sample, input y_sample, output ready);
endinterface

interface jhb_out_if;
  logic                         valid;
  logic                         ready;
  logic [jhb_pkg::INDEX_W-1:0]  bin_index;
  logic [jhb_pkg::COUNT_W-1:0]  bin_count;
  logic [jhb_pkg::COUNT_W-1:0]  largest_count;

  modport source (output valid, output bin_index, output bin_count, output largest_count,
                  input ready);
  modport sink (input valid, input bin_index, input bin_count, input largest_count,
                output ready);
endinterface
`default_nettype wire

[rtl/core/joint_histogram_binner.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted sample word passes the diff, multiply, bin, index,
// store read and store update states; the update, which registers the result,
// waits while a result is stalled, and no new word is taken until it is done.
// Reset (rst, synchronous): the 4096-entry count store is zeroed one entry
// per cycle; samples are refused until that is done; config writes still land.
module joint_histogram_binner (
  input  wire logic                             clk,
  input  wire logic                             rst,
  jhb_in_if.sink                                samples,
  jhb_out_if.source                             results,
  input  wire logic                             write_enable,
  input  wire logic [jhb_pkg::CFG_INDEX_W-1:0]  register_index,
  input  wire logic [jhb_pkg::CFG_DATA_W-1:0]   write_data
);
  import jhb_pkg::*;

  cmd_t    cmd;
  status_t status;

  jhb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  jhb_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .x_sample       (samples.x_sample),
    .y_sample       (samples.y_sample),
    .cmd            (cmd),
    .status         (status),
    .bin_index      (results.bin_index),
    .bin_count      (results.bin_count),
    .largest_count  (results.largest_count)
  );

endmodule
`default_nettype wire

[rtl/core/jhb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module jhb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output jhb_pkg::cmd_t         cmd,
  input  wire jhb_pkg::status_t status
);
  import jhb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next   = ST_DIFF;
        end
      end
      ST_DIFF:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_BIN;
      ST_BIN:   state_next = ST_INDEX;
      ST_INDEX: state_next = ST_READ;
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!out_valid || out_ready) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[rtl/core/jhb_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module jhb_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             write_enable,
  input  wire logic [jhb_pkg::CFG_INDEX_W-1:0]  register_index,
  input  wire logic [jhb_pkg::CFG_DATA_W-1:0]   write_data,
  input  wire logic [jhb_pkg::SAMPLE_W-1:0]     x_sample,
  input  wire logic [jhb_pkg::SAMPLE_W-1:0]     y_sample,
  input  wire jhb_pkg::cmd_t                    cmd,
  output jhb_pkg::status_t                      status,
  output logic [jhb_pkg::INDEX_W-1:0]           bin_index,
  output logic [jhb_pkg::COUNT_W-1:0]           bin_count,
  output logic [jhb_pkg::COUNT_W-1:0]           largest_count
);
  import jhb_pkg::*;

  logic [SAMPLE_W-1:0]   x_min, x_max, x_scale, y_min, y_max, y_scale;
  logic [BINS_REG_W-1:0] bins_x, bins_y;

  logic [SAMPLE_W-1:0]   x_in, y_in;
  logic [SAMPLE_W:0]     x_diff, y_diff;
  logic                  x_at_max, y_at_max;
  logic [SAMPLE_W-1:0]   x_raw, y_raw;
  logic [BIN_W-1:0]      x_bin, y_bin;
  logic [BINS_REG_W-1:0] bx, by;
  logic [ADDR_W-1:0]     addr;
  logic [ADDR_W:0]       addr_sum;
  logic [ADDR_W-1:0]     clr_addr;
  logic [COUNT_W-1:0]    rd_data;
  logic [COUNT_W-1:0]    count_new;
  logic [COUNT_W-1:0]    store [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min   <= '0;
      x_max   <= '0;
      x_scale <= SAMPLE_W'(65536);
      y_min   <= '0;
      y_max   <= '0;
      y_scale <= SAMPLE_W'(65536);
      bins_x  <= BINS_REG_W'(64);
      bins_y  <= BINS_REG_W'(64);
    end else if (write_enable) begin
      unique case (cfg_reg_t'(register_index))
        REG_X_MIN:   x_min   <= write_data;
        REG_X_MAX:   x_max   <= write_data;
        REG_X_SCALE: x_scale <= write_data;
        REG_Y_MIN:   y_min   <= write_data;
        REG_Y_MAX:   y_max   <= write_data;
        REG_Y_SCALE: y_scale <= write_data;
        REG_BINS_X:  bins_x  <= write_data[BINS_REG_W-1:0];
        REG_BINS_Y:  bins_y  <= write_data[BINS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_in <= x_sample;
      y_in <= y_sample;
    end
  end

  // stage pipeline, one step per controller state
  always_ff @(posedge clk) begin
    x_diff   <= {x_in[SAMPLE_W-1], x_in} - {x_min[SAMPLE_W-1], x_min};
    y_diff   <= {y_in[SAMPLE_W-1], y_in} - {y_min[SAMPLE_W-1], y_min};
    x_at_max <= (x_in == x_max);
    y_at_max <= (y_in == y_max);
    bx       <= clamp_bins(bins_x);
    by       <= clamp_bins(bins_y);
    x_raw    <= SAMPLE_W'(((2*SAMPLE_W)'(x_diff[SAMPLE_W-1:0]) *
                           (2*SAMPLE_W)'(x_scale)) >> SAMPLE_W);
    y_raw    <= SAMPLE_W'(((2*SAMPLE_W)'(y_diff[SAMPLE_W-1:0]) *
                           (2*SAMPLE_W)'(y_scale)) >> SAMPLE_W);
    x_bin    <= quantize(x_at_max, x_diff[SAMPLE_W], x_raw, bx);
    y_bin    <= quantize(y_at_max, y_diff[SAMPLE_W], y_raw, by);
    addr     <= addr_sum[ADDR_W] ? '1 : addr_sum[ADDR_W-1:0];
  end

  assign addr_sum = (ADDR_W+1)'(y_bin) + (ADDR_W+1)'(x_bin) * (ADDR_W+1)'(by);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign status.clear_last = (clr_addr == '1);

  assign count_new = (rd_data == '1) ? rd_data : rd_data + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      store[clr_addr] <= '0;
    end else if (cmd.update) begin
      store[addr] <= count_new;
    end
    if (cmd.mem_rd) begin
      rd_data <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      largest_count <= '0;
    end else if (cmd.update && (count_new > largest_count)) begin
      largest_count <= count_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      bin_index <= INDEX_W'(addr);
      bin_count <= count_new;
    end
  end

endmodule
`default_nettype wire

[rtl/core/jhb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module jhb_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [jhb_pkg::COUNT_W-1:0]     bin_count,
  input wire logic [jhb_pkg::COUNT_W-1:0]     largest_count
);
  import jhb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_largest_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> largest_count >= bin_count)
    else $error("largest count below delivered count");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bin_count != '0)
    else $error("delivered count is zero");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("ports active right after reset");

endmodule

bind joint_histogram_binner jhb_checker u_jhb_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (samples.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .bin_count     (results.bin_count),
  .largest_count (results.largest_count)
);
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import jhb_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 20000;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 100;

  typedef struct packed {
    logic [INDEX_W-1:0] bin;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] peak;
  } bin_result_t;

  typedef struct packed {
    logic        known;
    bin_result_t want;
  } note_t;

  typedef struct packed {
    logic        is_write;
    cfg_reg_t    target;
    logic [31:0] x_or_value;
    logic [31:0] y_value;
    logic        known;
    bin_result_t want;
  } plan_row_t;

  localparam bin_result_t NO_RESULT = '0;
  localparam int PLAN_LEN = 28;

  // row: is_write, register, x sample or write data, y sample, known, {bin, hits, peak}
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b0, REG_X_MIN, 32'h0000_0000, 32'h0000_0000, 1'b1, '{12'd4095, 32'd1, 32'd1}},
    '{1'b0, REG_X_MIN, 32'h8000_0000, 32'h8000_0000, 1'b1, '{12'd0, 32'd1, 32'd1}},
    '{1'b0, REG_X_MIN, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{12'd4032, 32'd1, 32'd1}},
    '{1'b0, REG_X_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{12'd63, 32'd1, 32'd1}},
    '{1'b0, REG_X_MIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{12'd4095, 32'd2, 32'd2}},
    '{1'b0, REG_X_MIN, 32'h0001_0000, 32'h0002_0000, 1'b1, '{12'd66, 32'd1, 32'd2}},
    '{1'b0, REG_X_MIN, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b1, '{12'd0, 32'd2, 32'd2}},
    '{1'b0, REG_X_MIN, 32'h0000_0000, 32'h0000_0000, 1'b1, '{12'd4095, 32'd3, 32'd3}},
    // bins above the axis size and zero bins, inverted x window, y scale of zero
    '{1'b1, REG_BINS_X, 32'hFFFF_FF7F, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, REG_BINS_Y, 32'h0000_0000, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, REG_X_MIN, 32'h0001_0000, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, REG_X_MAX, 32'hFFFF_0000, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, REG_X_SCALE, 32'hFFFF_FFFF, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, REG_Y_MIN, 32'h8000_0000, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, REG_Y_MAX, 32'h7FFF_FFFF, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, REG_Y_SCALE, 32'h0000_0000, 32'h0, 1'b0, NO_RESULT},
    '{1'b0, REG_X_MIN, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0, NO_RESULT},
    '{1'b0, REG_X_MIN, 32'h0001_0000, 32'h8000_0000, 1'b0, NO_RESULT},
    '{1'b0, REG_X_MIN, 32'h0001_8000, 32'h0000_0000, 1'b0, NO_RESULT},
    '{1'b0, REG_X_MIN, 32'h0000_0000, 32'h1234_5678, 1'b0, NO_RESULT},
    '{1'b0, REG_X_MIN, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
    // geometry change with the store kept
    '{1'b1, REG_BINS_Y, 32'h0000_0002, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, REG_Y_SCALE, 32'h0002_0000, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, REG_Y_MIN, 32'h0000_0000, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, REG_Y_MAX, 32'h0001_0000, 32'h0, 1'b0, NO_RESULT},
    '{1'b0, REG_X_MIN, 32'h0001_0000, 32'h0000_8000, 1'b0, NO_RESULT},
    '{1'b0, REG_X_MIN, 32'hFFFF_0000, 32'h0001_0000, 1'b0, NO_RESULT},
    '{1'b0, REG_X_MIN, 32'h0002_0000, 32'h0000_7FFF, 1'b0, NO_RESULT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        write_enable = 1'b0;
  cfg_reg_t    reg_sel = REG_X_MIN;
  logic [31:0] write_data = '0;

  jhb_in_if  samples ();
  jhb_out_if results ();

  joint_histogram_binner dut (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .write_enable(write_enable), .register_index(reg_sel), .write_data(write_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [31:0]  cfg_mirror [8] = '{32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65536,
                                   32'd64, 32'd64};
  logic [COUNT_W-1:0] bin_counts [STORE_DEPTH];
  logic [COUNT_W-1:0] peak_count = '0;

  note_t       sent_notes [$];
  bin_result_t due_bins [$];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          failures = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          settings_used = 1;
  int          quiet = 0;
  note_t       taken_note;
  bin_result_t seen, owed;
  logic        moved;

  initial foreach (bin_counts[i]) bin_counts[i] = '0;

  function automatic logic [6:0] axis_size(input logic [31:0] r);
    if (r[6:0] == 7'd0) return 7'd1;
    if (r[6:0] > 7'd64) return 7'd64;
    return r[6:0];
  endfunction

  function automatic logic [6:0] axis_bin(input logic [31:0] s, lo, hi, scale,
                                          input logic [6:0] nbins);
    logic [32:0] diff;
    logic [63:0] prod;
    if (s == hi) return nbins - 7'd1;
    diff = {s[31], s} - {lo[31], lo};
    if (diff[32]) return 7'd0;
    prod = {32'd0, diff[31:0]} * {32'd0, scale};
    if (prod[63:32] >= {25'd0, nbins}) return nbins - 7'd1;
    return prod[38:32];
  endfunction

  function automatic bin_result_t tally_pair(input logic [31:0] x, y);
    logic [6:0]  bx, by, xb, yb;
    logic [11:0] idx;
    bx = axis_size(cfg_mirror[REG_BINS_X]);
    by = axis_size(cfg_mirror[REG_BINS_Y]);
    xb = axis_bin(x, cfg_mirror[REG_X_MIN], cfg_mirror[REG_X_MAX], cfg_mirror[REG_X_SCALE], bx);
    yb = axis_bin(y, cfg_mirror[REG_Y_MIN], cfg_mirror[REG_Y_MAX], cfg_mirror[REG_Y_SCALE], by);
    idx = 12'(yb) + 12'(xb) * 12'(by);
    if (bin_counts[idx] != '1) bin_counts[idx] = bin_counts[idx] + COUNT_W'(1);
    if (bin_counts[idx] > peak_count) peak_count = bin_counts[idx];
    return '{idx, bin_counts[idx], peak_count};
  endfunction

  function automatic logic [31:0] pick_sample(input logic signed [31:0] lo, hi);
    longint span;
    span = longint'(hi) - longint'(lo);
    case ($urandom_range(9))
      0: return lo;
      1: return hi;
      2: return $urandom();
      default: begin
        if (span <= 0 || span >= longint'(32'h4000_0000)) return $urandom();
        return 32'(longint'(lo) - span / 8 + longint'($urandom_range(0, 32'(span + span / 4))));
      end
    endcase
  endfunction

  function automatic logic [6:0] pick_bins();
    case ($urandom_range(7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'($urandom_range(65, 127));
      4, 5: return 7'($urandom_range(2, 8));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic choose_axis(input int mode, input logic [6:0] bins_raw,
                             output logic [31:0] lo, hi, scale);
    logic [6:0]  n;
    logic [31:0] span;
    logic [63:0] q;
    n = axis_size({25'd0, bins_raw});
    lo = 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
    span = $urandom_range(16, 32'h0400_0000);
    case (mode)
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
        scale = {25'd0, n};
      end
      1: begin
        hi = lo + span;
        q = {25'd0, n, 32'd0} / {32'd0, span};
        scale = (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
      end
      2: begin
        hi = lo - span;
        scale = $urandom();
      end
      default: begin
        lo = $urandom();
        hi = $urandom();
        case ($urandom_range(2))
          0: scale = '0;
          1: scale = '1;
          default: scale = $urandom();
        endcase
      end
    endcase
  endtask

  task automatic write_reg(input cfg_reg_t target, input logic [31:0] value);
    write_enable <= 1'b1;
    reg_sel <= target;
    write_data <= value;
    cfg_mirror[target] = value;
    @(posedge clk);
  endtask

  task automatic program_phase(input int ph);
    logic [6:0]  nx, ny;
    logic [31:0] lo, hi, sc;
    int          mx, my;
    case (ph)
      0: begin
        nx = 7'd64; ny = 7'd64; mx = 0; my = 0;
      end
      1: begin
        nx = 7'd127; ny = 7'd0; mx = 2; my = 3;
      end
      2: begin
        nx = 7'd1; ny = 7'd1; mx = 3; my = 3;
      end
      default: begin
        nx = pick_bins();
        ny = pick_bins();
        mx = ($urandom_range(3) == 0) ? int'($urandom_range(2, 3)) : 1;
        my = ($urandom_range(3) == 0) ? int'($urandom_range(2, 3)) : 1;
      end
    endcase
    choose_axis(mx, nx, lo, hi, sc);
    write_reg(REG_X_MIN, lo);
    write_reg(REG_X_MAX, hi);
    write_reg(REG_X_SCALE, sc);
    choose_axis(my, ny, lo, hi, sc);
    write_reg(REG_Y_MIN, lo);
    write_reg(REG_Y_MAX, hi);
    write_reg(REG_Y_SCALE, sc);
    // upper bits of the bins words are don't-care
    write_reg(REG_BINS_X, ($urandom() & 32'hFFFF_FF80) | {25'd0, nx});
    write_reg(REG_BINS_Y, ($urandom() & 32'hFFFF_FF80) | {25'd0, ny});
    write_enable <= 1'b0;
  endtask

  task automatic send_word(input logic [31:0] x, y, input logic known,
                           input bin_result_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sent_notes.push_back(note_t'{known, want});
    samples.valid <= 1'b1;
    samples.x_sample <= x;
    samples.y_sample <= y;
    do @(posedge clk); while (!samples.ready);
  endtask

  task automatic wait_drained();
    samples.valid <= 1'b0;
    while (due_bins.size() != 0 || sent_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    results.ready = 1'b0;
    forever begin
      @(posedge clk);
      results.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      moved = (samples.valid && samples.ready) || (results.valid && results.ready);
      if (results.valid && results.ready) begin
        words_out++;
        seen = '{results.bin_index, results.bin_count, results.largest_count};
        if (due_bins.size() == 0) begin
          $error("result word with nothing pending: bin_index %0d", seen.bin);
          failures++;
        end else begin
          owed = due_bins.pop_front();
          if (seen.bin !== owed.bin) begin
            $error("bin_index: expected %0d, got %0d", owed.bin, seen.bin);
            failures++;
          end
          if (seen.hits !== owed.hits) begin
            $error("bin_count: expected %0d, got %0d", owed.hits, seen.hits);
            failures++;
          end
          if (seen.peak !== owed.peak) begin
            $error("largest_count: expected %0d, got %0d", owed.peak, seen.peak);
            failures++;
          end
        end
      end
      if (samples.valid && samples.ready) begin
        words_in++;
        taken_note = sent_notes.pop_front();
        owed = tally_pair(samples.x_sample, samples.y_sample);
        due_bins.push_back(taken_note.known ? taken_note.want : owed);
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("joint_histogram_binner regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic writing;
    writing = 1'b0;
    samples.valid = 1'b0;
    samples.x_sample = '0;
    samples.y_sample = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      if (PLAN[i].is_write) begin
        if (!writing) wait_drained();
        writing = 1'b1;
        write_reg(PLAN[i].target, PLAN[i].x_or_value);
      end else begin
        if (writing) begin
          write_enable <= 1'b0;
          writing = 1'b0;
          settings_used++;
        end
        send_word(PLAN[i].x_or_value, PLAN[i].y_value, PLAN[i].known, PLAN[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      program_phase(ph);
      settings_used++;
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 5 && k == PHASE_WORDS / 2) wait_drained();
        send_word(pick_sample(cfg_mirror[REG_X_MIN], cfg_mirror[REG_X_MAX]),
                  pick_sample(cfg_mirror[REG_Y_MIN], cfg_mirror[REG_Y_MAX]),
                  1'b0, NO_RESULT);
      end
    end
    wait_drained();

    $display("covered %0d sample words and %0d bin updates over %0d register settings,",
             words_in, words_out, settings_used);
    $display("with sender gaps and receiver stalls at 0, 30 and 68 percent");
    if (failures == 0) begin
      $display("joint_histogram_binner regression: pass");
    end else begin
      $display("joint_histogram_binner regression: fail");
    end
    $finish;
  end

endmodule
